FILE: rtl/fpatan_pkg.sv
// ----------------------------------------------------------------------------
// fpatan_pkg
// shared constants and types for the octant-reduction atan2 pipeline
// ----------------------------------------------------------------------------
package fpatan_pkg;

	// operand width after folding: values reach 2^32
	localparam int VBITS      = 33;
	// quotient bits kept: (q * 8192) >> 16 equals floor(y * 2^13 / x)
	localparam int QBITS      = 13;
	// base angle counted in eighth turns
	localparam int PBITS      = 3;
	localparam int DIV_STAGES = QBITS;
	localparam int ABITS      = PBITS + QBITS;

	localparam logic [PBITS-1:0] PHI_ZERO    = 3'd0;
	localparam logic [PBITS-1:0] PHI_EIGHTH  = 3'd1;
	localparam logic [PBITS-1:0] PHI_QUARTER = 3'd2;
	localparam logic [PBITS-1:0] PHI_HALF    = 3'd4;

	typedef struct packed {
		logic [VBITS-1:0] divisor;
		logic [VBITS-1:0] rem;
		logic [QBITS-1:0] quo;
		logic [PBITS-1:0] phi;
	} div_word_t;

endpackage

FILE: rtl/fpatan_div_stage.sv
// ----------------------------------------------------------------------------
// fpatan_div_stage
// one registered restoring-division step: one quotient bit per stage
// ----------------------------------------------------------------------------
module fpatan_div_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  fpatan_pkg::div_word_t in_word,
	output logic                  out_valid,
	output fpatan_pkg::div_word_t out_word
);
	import fpatan_pkg::*;

	logic [VBITS:0] shifted;
	logic [VBITS:0] diff;
	logic           take;
	div_word_t      next_word;

	always_comb begin
		shifted = {in_word.rem, 1'b0};
		diff    = shifted - {1'b0, in_word.divisor};
		take    = ~diff[VBITS];
		next_word         = in_word;
		next_word.rem     = take ? diff[VBITS-1:0] : shifted[VBITS-1:0];
		next_word.quo     = {in_word.quo[QBITS-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= next_word;
		end
	end

endmodule

FILE: rtl/fixed_point_atan2_octant_linear_top.sv
// ----------------------------------------------------------------------------
// fixed_point_atan2_octant_linear_top
// atan2 of signed 16.16 (y, x) to a 16-bit binary angle
// stages: two fold stages, then thirteen restoring-division stages, the last
//   one being the output register
// throughput: one request per cycle unless out_ready stalls a full pipeline;
//   every stage holds its own valid bit and empty stages fill up in a stall
// reset: arst_n clears all valid bits asynchronously; payload is not reset
// ----------------------------------------------------------------------------
module fixed_point_atan2_octant_linear_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [31:0]             y_coord,
	input  logic signed [31:0]             x_coord,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fpatan_pkg::ABITS-1:0]   angle
);
	import fpatan_pkg::*;

	// stage 1: zero-y handling and lower half-plane fold
	logic                    v_s1;
	logic signed [VBITS-1:0] y_s1;
	logic signed [VBITS-1:0] x_s1;
	logic [PBITS-1:0]        phi_s1;
	logic                    en_s1;

	// stage 2: quadrant and diagonal folds, result is the divider input
	logic                    v_s2;
	div_word_t               w_s2;
	logic                    en_s2;

	// division stages
	logic                    v_div  [DIV_STAGES];
	div_word_t               w_div  [DIV_STAGES];
	logic                    en_div [DIV_STAGES];

	logic signed [VBITS-1:0] y_ext;
	logic signed [VBITS-1:0] x_ext;
	logic signed [VBITS-1:0] y_f1;
	logic signed [VBITS-1:0] x_f1;
	logic [PBITS-1:0]        phi_f1;

	logic [VBITS-1:0]        xa;
	logic [VBITS-1:0]        ya;
	logic [PBITS-1:0]        phi_a;
	div_word_t               w_f2;

	// a stage may load when it is empty or its contents move on
	assign en_s1    = ~v_s1 | en_s2;
	assign en_s2    = ~v_s2 | en_div[0];
	assign in_ready = en_s1;

	// half-plane fold; zero y becomes the vector (1, 0) so the divider gives 0
	always_comb begin
		y_ext  = VBITS'(y_coord);
		x_ext  = VBITS'(x_coord);
		y_f1   = y_ext;
		x_f1   = x_ext;
		phi_f1 = PHI_ZERO;
		if (y_coord == '0) begin
			y_f1   = '0;
			x_f1   = VBITS'(1);
			phi_f1 = x_coord[31] ? PHI_HALF : PHI_ZERO;
		end else if (y_coord[31]) begin
			// negating -2^31 is exact in 33 bits
			y_f1   = -y_ext;
			x_f1   = -x_ext;
			phi_f1 = PHI_HALF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			y_s1   <= y_f1;
			x_s1   <= x_f1;
			phi_s1 <= phi_f1;
		end
	end

	// quadrant fold then diagonal fold; both values are nonnegative from here
	always_comb begin
		xa    = x_s1;
		ya    = y_s1;
		phi_a = phi_s1;
		if (x_s1 <= 0) begin
			xa    = y_s1;
			ya    = -x_s1;
			phi_a = phi_s1 + PHI_QUARTER;
		end
		w_f2         = '0;
		w_f2.divisor = xa;
		w_f2.rem     = ya;
		w_f2.phi     = phi_a;
		// sum reaches 2^32 at most, held unsigned in 33 bits
		if (xa <= ya) begin
			w_f2.divisor = xa + ya;
			w_f2.rem     = ya - xa;
			w_f2.phi     = phi_a + PHI_EIGHTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			w_s2 <= w_f2;
		end
	end

	// restoring division chain, remainder starts below the divisor
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		if (i == DIV_STAGES - 1) begin : g_last
			assign en_div[i] = ~v_div[i] | out_ready;
		end else begin : g_mid
			assign en_div[i] = ~v_div[i] | en_div[i+1];
		end

		if (i == 0) begin : g_first
			fpatan_div_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en_div[i]),
				.in_valid  (v_s2),
				.in_word   (w_s2),
				.out_valid (v_div[i]),
				.out_word  (w_div[i])
			);
		end else begin : g_next
			fpatan_div_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en_div[i]),
				.in_valid  (v_div[i-1]),
				.in_word   (w_div[i-1]),
				.out_valid (v_div[i]),
				.out_word  (w_div[i])
			);
		end
	end

	// base angle in eighth turns plus a correction below one eighth: no carry
	assign out_valid = v_div[DIV_STAGES-1];
	assign angle     = {w_div[DIV_STAGES-1].phi, w_div[DIV_STAGES-1].quo};

endmodule

FILE: test/tb_fixed_point_atan2_octant_linear_top.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_atan2_octant_linear_top
// self-checking bench for the octant-reduction atan2 pipeline
// a table of directed vectors (axes, extremes, diagonals, all octants but one) is
// followed by about 950 random vectors drawn from several distributions;
// requests go in bursts with random gaps while the result side stalls on its
// own pattern, including one long hold-off that backs the pipeline up; every
// angle is compared in order against a hand-worked angle or an in-bench
// prediction of the folding and the linear correction
// ----------------------------------------------------------------------------
module tb_fixed_point_atan2_octant_linear_top;

	timeunit 1ns;
	timeprecision 1ps;

	import fpatan_pkg::*;

	localparam int N_DIRECTED  = 24;
	localparam int N_RANDOM    = 950;
	// pipeline depth plus some slack for the drain at the end
	localparam int DRAIN_CYCLES = 40;
	// long receiver hold-off, well beyond the pipeline depth
	localparam int HOLD_CYCLES  = 120;

	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] C_MAX = 32'sh7fff_ffff;

	// one row of the directed table: known rows carry a hand-worked angle
	typedef struct packed {
		logic signed [31:0] y;
		logic signed [31:0] x;
		logic               known;
		logic [ABITS-1:0]   angle;
	} vec_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic signed [31:0]       y_coord;
	logic signed [31:0]       x_coord;
	logic                     out_valid;
	logic                     out_ready;
	logic [ABITS-1:0]         angle;

	// angles still owed by the pipeline, oldest first
	logic [ABITS-1:0]         pending_angles[$];
	int                       n_fail;
	int                       n_accepted;
	int                       burst_left;

	fixed_point_atan2_octant_linear_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.y_coord   (y_coord),
		.x_coord   (x_coord),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.angle     (angle)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// fold the vector into the first octant, accumulating the base angle in
	// eighth turns, then add floor(y * 2^13 / x) as the linear correction
	function automatic logic [ABITS-1:0] fold_atan_angle(input logic signed [31:0] yi,
			input logic signed [31:0] xi);
		longint           y;
		longint           x;
		longint           t;
		longint           q;
		logic [PBITS-1:0] phi;
		logic [ABITS-1:0] dphi;
		y   = yi;
		x   = xi;
		phi = PHI_ZERO;
		// on the x axis the angle is either nothing or a half turn
		if (y == 0) begin
			return (x >= 0) ? {PHI_ZERO, {QBITS{1'b0}}} : {PHI_HALF, {QBITS{1'b0}}};
		end
		// lower half plane: rotate by a half turn
		if (y < 0) begin
			x   = -x;
			y   = -y;
			phi = phi + PHI_HALF;
		end
		// left quadrant: rotate by a quarter turn
		if (x <= 0) begin
			t   = -x;
			x   = y;
			y   = t;
			phi = phi + PHI_QUARTER;
		end
		// above the diagonal: rotate by an eighth turn, sum may reach 2^32
		if (x <= y) begin
			t   = y - x;
			x   = x + y;
			y   = t;
			phi = phi + PHI_EIGHTH;
		end
		q    = (y <<< 16) / x;
		dphi = ABITS'((q * 8192) >>> 16);
		return {phi, {QBITS{1'b0}}} + dphi;
	endfunction

	// directed vectors: axes, extremes, diagonals, and a point in every octant but the one from 5/8 to 6/8 turn
	function automatic vec_row_t directed_row(input int i);
		case (i)
			0:  return '{32'sd0,           32'sd0,           1'b1, 16'h0000};
			1:  return '{32'sd0,           -32'sd1,          1'b1, 16'h8000};
			2:  return '{32'sd0,           C_MAX,            1'b1, 16'h0000};
			3:  return '{32'sd0,           C_MIN,            1'b1, 16'h8000};
			4:  return '{32'sd1,           32'sd1,           1'b1, 16'h2000};
			5:  return '{C_MIN,            C_MIN,            1'b1, 16'ha000};
			6:  return '{C_MAX,            32'sd0,           1'b1, 16'h4000};
			7:  return '{C_MIN,            32'sd0,           1'b1, 16'hc000};
			8:  return '{-32'sd1,          32'sd1,           1'b1, 16'he000};
			9:  return '{32'sd1,           C_MAX,            1'b1, 16'h0000};
			10: return '{C_MAX,            C_MAX,            1'b1, 16'h2000};
			11: return '{C_MAX,            C_MIN,            1'b1, 16'h6000};
			12: return '{C_MIN,            C_MAX,            1'b1, 16'hdfff};
			13: return '{-32'sd1,          -32'sd1,          1'b1, 16'ha000};
			14: return '{-32'sd1,          32'sd0,           1'b1, 16'hc000};
			15: return '{32'sd1,           -32'sd1,          1'b1, 16'h6000};
			16: return '{32'sh0001_0000,   32'sh0002_0000,   1'b0, 16'h0000};
			17: return '{-32'sh0001_8000,  32'sh0003_0000,   1'b0, 16'h0000};
			18: return '{32'sh1234_5678,   -32'sh0abc_def0,  1'b0, 16'h0000};
			19: return '{-32'sd5,          -32'sd7,          1'b0, 16'h0000};
			20: return '{32'sd3,           -32'sd100,        1'b0, 16'h0000};
			21: return '{-32'sd100,        32'sd3,           1'b0, 16'h0000};
			22: return '{32'sh4000_0000,   32'sh3fff_ffff,   1'b0, 16'h0000};
			default: return '{32'sh5555_5555, -32'sh2aaa_aaab, 1'b0, 16'h0000};
		endcase
	endfunction

	// a coordinate of random sign and random magnitude scale
	function automatic logic signed [31:0] scaled_coord();
		logic signed [31:0] v;
		v = $urandom >> $urandom_range(0, 31);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// hold the request until it is taken, then book the angle it owes
	task automatic offer_vector(input logic signed [31:0] yv, input logic signed [31:0] xv,
			input logic [ABITS-1:0] want);
		int gap;
		in_valid <= 1'b1;
		y_coord  <= yv;
		x_coord  <= xv;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_angles.push_back(want);
		n_accepted++;
		// end of burst: idle for a while, or carry straight on
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
			                                         : $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// stimulus
	initial begin
		vec_row_t           row;
		logic signed [31:0] yv;
		logic signed [31:0] xv;
		int                 pick;
		n_accepted = 0;
		burst_left = 4;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		y_coord   <= '0;
		x_coord   <= '0;
		repeat (4) @(posedge clk);
		arst_n    <= 1'b1;
		@(posedge clk);

		// directed table: typed-in angles where known, prediction otherwise
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = directed_row(i);
			offer_vector(row.y, row.x,
				row.known ? row.angle : fold_atan_angle(row.y, row.x));
		end

		// random vectors from a mix of distributions
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// full 32-bit range, every bit toggles
				yv = $urandom;
				xv = $urandom;
			end else if (pick < 60) begin
				// small magnitudes around the origin
				yv = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
				xv = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			end else if (pick < 75) begin
				// on or near a diagonal or an axis
				xv = scaled_coord();
				case ($urandom_range(0, 3))
					0: yv = xv + $signed($urandom_range(0, 4)) - 2;
					1: yv = -xv + $signed($urandom_range(0, 4)) - 2;
					2: yv = '0;
					default: begin
						yv = xv;
						xv = '0;
					end
				endcase
			end else if (pick < 85) begin
				// corner values
				case ($urandom_range(0, 4))
					0: yv = C_MIN;
					1: yv = C_MAX;
					2: yv = -32'sd1;
					3: yv = 32'sd1;
					default: yv = '0;
				endcase
				case ($urandom_range(0, 4))
					0: xv = C_MIN;
					1: xv = C_MAX;
					2: xv = -32'sd1;
					3: xv = 32'sd1;
					default: xv = scaled_coord();
				endcase
			end else begin
				// independent magnitude scales, wide ratios both ways
				yv = scaled_coord();
				xv = scaled_coord();
			end
			offer_vector(yv, xv, fold_atan_angle(yv, xv));
		end
		in_valid <= 1'b0;

		// drain, then allow for any stray output
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_fail == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// result side: stretches of full rate, random stalls and a fixed pattern,
	// with one long hold-off early on so the pipeline fills and pushes back
	initial begin
		int   mode;
		int   len;
		logic held;
		out_ready <= 1'b0;
		held = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && n_accepted >= 100) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(5, 60);
			for (int c = 0; c < len; c++) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 99) >= 25;
					2: out_ready <= $urandom_range(0, 99) >= 70;
					default: out_ready <= (c % 3) != 0;
				endcase
				@(posedge clk);
			end
		end
	end

	// compare every delivered angle with the oldest one owed
	always @(posedge clk) begin
		logic [ABITS-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_angles.size() == 0) begin
				$error("angle: unexpected result %h with nothing outstanding", angle);
				n_fail++;
			end else begin
				want = pending_angles.pop_front();
				if (angle !== want) begin
					$error("angle mismatch: expected %h, got %h", want, angle);
					n_fail++;
				end
			end
		end
	end

	// watchdog
	initial begin
		n_fail = 0;
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
